// ===== rtl/assert_macros.svh =====
// Assertion macros included by the row packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/ffrp_pkg.sv =====
// Types and constants of the first-fit row packer.
package ffrp_pkg;

    // Field widths
    localparam int START_W    = 31;
    localparam int PAD_W      = 16;
    localparam int IW_W       = 20;
    localparam int X_W        = 41;
    localparam int Y_W        = 15;
    localparam int ROWN_W     = 6;
    localparam int END_W      = 42;
    localparam int DIFF_W     = 33;
    localparam int WSUM_W     = 21;

    // Configuration registers
    localparam int LB_W       = 31;
    localparam int CW_W       = 7;
    localparam int HH_W       = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_BOUND    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_HEIGHT = 2'd2;

    localparam logic [CW_W-1:0] CHAR_WIDTH_RESET = 7'd8;

    // Left margin of the view in pixels
    localparam logic [X_W-1:0] VIEW_MARGIN_PX = 41'd5;

    // Row pitch is 15 px of text plus 2 px spacer = 17 = 16 + 1
    localparam int ROW_PITCH_SHIFT = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADDX,
        ST_SCAN,
        ST_FIN
    } t_state;

endpackage

// ===== rtl/first_fit_row_packer.sv =====
// First-fit row packer: places intervals into display rows, one row end per cycle.
//
//  channel   | ports                                            | handshake
//  ----------+--------------------------------------------------+--------------------------
//  item in   | i_new_layout i_read_start i_pad_count i_item_width | start high, busy low
//  result    | o_x_pixel o_y_pixel o_row_number o_no_room       | o_valid, one-cycle strobe
//  config    | i_cfg_we i_cfg_addr i_cfg_data                   | i_cfg_we, no wait
//
// After accept an item passes through the MUL, ADDX, SCAN and FIN states; the scan
// compares k rows (1 to MAX_ROWS), reading the row table, which has one write and
// one read port, one entry and one compare per cycle.
// busy is high from the cycle after accept until the result strobe.
// Reset (synchronous, active low) opens one row with end 0 and loads the
// config defaults; no clearing pass is needed. Results cannot be stalled.
`include "assert_macros.svh"

module first_fit_row_packer #(
    parameter int MAX_ROWS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // item in
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_new_layout,
    input  logic [ffrp_pkg::START_W-1:0]         i_read_start,
    input  logic [ffrp_pkg::PAD_W-1:0]           i_pad_count,
    input  logic [ffrp_pkg::IW_W-1:0]            i_item_width,
    // result
    output logic                                 o_valid,
    output logic signed [ffrp_pkg::X_W-1:0]      o_x_pixel,
    output logic [ffrp_pkg::Y_W-1:0]             o_y_pixel,
    output logic [ffrp_pkg::ROWN_W-1:0]          o_row_number,
    output logic                                 o_no_room,
    // config
    input  logic                                 i_cfg_we,
    input  logic [ffrp_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [ffrp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import ffrp_pkg::*;

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int YS_W  = ROW_W + 16;
    localparam int RX_W  = ROW_W + ROWN_W;

    // Config registers
    logic [LB_W-1:0]                r_left_bound;
    logic [CW_W-1:0]                r_char_width;
    logic [HH_W-1:0]                r_header_height;

    // Sequencer and row bookkeeping
    t_state                         r_state, n_state;
    logic [CNT_W-1:0]               r_rows_open, n_rows_open;
    logic                           r_row0_clr, n_row0_clr;
    logic [ROW_W-1:0]               r_row, n_row;
    logic                           r_hit, n_hit;

    // Datapath
    logic signed [DIFF_W-1:0]       r_diff;
    logic [WSUM_W-1:0]              r_wsum;
    logic signed [X_W-1:0]          r_prod;
    logic signed [X_W-1:0]          r_x;

    // Result registers
    logic                           r_out_valid, n_out_valid;
    logic signed [X_W-1:0]          r_out_x;
    logic [Y_W-1:0]                 r_out_y, n_out_y;
    logic [ROWN_W-1:0]              r_out_row, n_out_row;
    logic                           r_out_no_room, n_out_no_room;

    // Row-end table
    logic signed [END_W-1:0]        r_row_end [MAX_ROWS];
    logic signed [END_W-1:0]        r_rd_data;
    logic [ROW_W-1:0]               rd_addr;
    logic                           mem_we;

    logic signed [END_W-1:0]        x_ext;
    logic signed [END_W-1:0]        end_val;
    logic signed [END_W-1:0]        new_end;
    logic                           fits;
    logic                           last_row;
    logic                           accept;
    logic [YS_W-1:0]                y_sum;
    logic [RX_W-1:0]                row_ext;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    // Config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_bound    <= '0;
            r_char_width    <= CHAR_WIDTH_RESET;
            r_header_height <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_LEFT_BOUND:    r_left_bound    <= i_cfg_data[LB_W-1:0];
                CFG_CHAR_WIDTH:    r_char_width    <= i_cfg_data[CW_W-1:0];
                CFG_HEADER_HEIGHT: r_header_height <= i_cfg_data[HH_W-1:0];
                default: ;
            endcase
        end
    end

    // Scan compare: row 0 reads as end 0 until written after a clear
    assign x_ext    = END_W'(r_x);
    assign end_val  = ((r_row == '0) && r_row0_clr) ? '0 : r_rd_data;
    assign fits     = (x_ext >= end_val);
    assign last_row = ((CNT_W'(r_row) + CNT_W'(1)) == r_rows_open);
    assign new_end  = x_ext + $signed({{(END_W-WSUM_W){1'b0}}, r_wsum});

    // y = row * 17 + header_height, low bits kept
    assign y_sum   = YS_W'({r_row, {ROW_PITCH_SHIFT{1'b0}}}) + YS_W'(r_row)
                   + YS_W'(r_header_height);
    assign row_ext = RX_W'(r_row);

    // Next state and control
    always_comb begin
        n_state       = r_state;
        n_rows_open   = r_rows_open;
        n_row0_clr    = r_row0_clr;
        n_row         = r_row;
        n_hit         = r_hit;
        n_out_valid   = 1'b0;
        n_out_y       = r_out_y;
        n_out_row     = r_out_row;
        n_out_no_room = r_out_no_room;
        rd_addr       = '0;
        mem_we        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_MUL;
                    if (i_new_layout) begin
                        n_rows_open = CNT_W'(1);
                        n_row0_clr  = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                n_state = ST_ADDX;
            end
            ST_ADDX: begin
                // first read of row 0 goes out here
                n_state = ST_SCAN;
                n_row   = '0;
                rd_addr = '0;
            end
            ST_SCAN: begin
                rd_addr = r_row + ROW_W'(1);
                if (fits) begin
                    n_hit   = 1'b1;
                    n_state = ST_FIN;
                end else if (last_row) begin
                    n_state = ST_FIN;
                    if (r_rows_open < CNT_W'(MAX_ROWS)) begin
                        n_row       = r_rows_open[ROW_W-1:0];
                        n_rows_open = r_rows_open + CNT_W'(1);
                        n_hit       = 1'b1;
                    end else begin
                        n_hit = 1'b0;
                    end
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end
            ST_FIN: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b1;
                if (r_hit) begin
                    mem_we        = 1'b1;
                    n_out_y       = y_sum[Y_W-1:0];
                    n_out_row     = row_ext[ROWN_W-1:0];
                    n_out_no_room = 1'b0;
                    if (r_row == '0) begin
                        n_row0_clr = 1'b0;
                    end
                end else begin
                    n_out_y       = '0;
                    n_out_row     = '0;
                    n_out_no_room = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rows_open <= CNT_W'(1);
            r_row0_clr  <= 1'b1;
            r_row       <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rows_open <= n_rows_open;
            r_row0_clr  <= n_row0_clr;
            r_row       <= n_row;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers: offset, multiply, margin add
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_diff <= $signed({2'b0, i_read_start}) + $signed({17'b0, i_pad_count})
                    - $signed({2'b0, r_left_bound});
            r_wsum <= WSUM_W'(i_item_width) + WSUM_W'({r_char_width, 1'b0});
        end
        if (r_state == ST_MUL) begin
            r_prod <= r_diff * $signed({1'b0, r_char_width});
        end
        if (r_state == ST_ADDX) begin
            r_x <= r_prod + $signed(VIEW_MARGIN_PX);
        end
        if (r_state == ST_FIN) begin
            r_out_x <= r_x;
        end
        r_out_y       <= n_out_y;
        r_out_row     <= n_out_row;
        r_out_no_room <= n_out_no_room;
    end

    // Row-end table: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_row_end[r_row] <= new_end;
        end
        r_rd_data <= r_row_end[rd_addr];
    end

    assign o_valid      = r_out_valid;
    assign o_x_pixel    = r_out_x;
    assign o_y_pixel    = r_out_y;
    assign o_row_number = r_out_row;
    assign o_no_room    = r_out_no_room;

    // Checks
    `ASSERT_NEXT(a_strobe_after_fin, i_clk, i_rst_n, r_state == ST_FIN, o_valid, "strobe missing after FIN")
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted item did not raise busy")
    `ASSERT_SAME(a_rows_open_range, i_clk, i_rst_n, 1'b1, (r_rows_open != '0) && (r_rows_open <= CNT_W'(MAX_ROWS)), "rows_open out of range")
    `ASSERT_SAME(a_no_room_full, i_clk, i_rst_n, o_valid && o_no_room, r_rows_open == CNT_W'(MAX_ROWS), "no_room with free rows")

endmodule
